### hw/rtl/cau_pkg.sv
// ----------------------------------------------------------------------------
// cau_pkg
// shared types and constants of the complex arithmetic unit
// ----------------------------------------------------------------------------
package cau_pkg;

  localparam int DATA_W = 16;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef struct packed {
    logic [1:0]               req_type;
    logic signed [DATA_W-1:0] a_re;
    logic signed [DATA_W-1:0] a_im;
    logic signed [DATA_W-1:0] b_re;
    logic signed [DATA_W-1:0] b_im;
  } req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] res_re;
    logic signed [DATA_W-1:0] res_im;
    logic                     saturated;
    logic                     div_by_zero;
  } res_t;

  // control and early results carried alongside the divider chain
  typedef struct packed {
    logic [DATA_W-1:0] res_re;
    logic [DATA_W-1:0] res_im;
    logic              sat;
    logic              dz;
    logic              is_div;
    logic              neg_re;
    logic              neg_im;
  } side_t;

endpackage

### hw/rtl/complex_arith_unit.sv
// ----------------------------------------------------------------------------
// complex_arith_unit
// pipelined complex add, subtract, multiply and divide on signed fixed point
// ----------------------------------------------------------------------------
// path: every request passes stages 1 to 3, then the divider chain of one cell per
// quotient bit, then the output register
// throughput: one request per cycle unless stalled, all operations share the same pipeline
// the whole pipeline holds while a result waits under res_stall
// reset: synchronous rst clears all valid bits, payload registers are not reset
module complex_arith_unit #(
  parameter int FRAC_BITS = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  cau_pkg::req_t req,
  output logic          res_valid,
  input  logic          res_stall,
  output cau_pkg::res_t res
);

  localparam int W  = cau_pkg::DATA_W;
  localparam int PW = 2 * W;          // product width
  localparam int SW = 2 * W + 1;      // sum of two products
  localparam int DW = 2 * W;          // denominator, unsigned
  localparam int NW = 2 * W;          // numerator magnitude
  localparam int QW = NW + FRAC_BITS; // scaled dividend and quotient

  localparam logic signed [SW-1:0] MAXV = SW'((64'd1 << (W - 1)) - 64'd1);
  localparam logic signed [SW-1:0] MINV = -MAXV - SW'(1);
  localparam logic signed [SW-1:0] RND  = SW'((64'd1 << FRAC_BITS) - 64'd1);
  localparam logic [QW-1:0]        QPOS = QW'((64'd1 << (W - 1)) - 64'd1);
  localparam logic [QW-1:0]        QNEG = QW'(64'd1 << (W - 1));

  // clip to the signed result range, flag in the top bit
  function automatic logic [W:0] clip(input logic signed [SW-1:0] x);
    logic [W:0] r;
    if (x > MAXV) begin
      r = {1'b1, MAXV[W-1:0]};
    end else if (x < MINV) begin
      r = {1'b1, MINV[W-1:0]};
    end else begin
      r = {1'b0, x[W-1:0]};
    end
    return r;
  endfunction

  // global advance: move unless the output holds a stalled result
  logic en;
  assign en        = !(res_valid && res_stall);
  assign req_stall = !en;

  // stage 1: products and part-wise add/sub
  logic                v1;
  cau_pkg::op_t        op1;
  logic signed [PW-1:0] p_rr, p_ii, p_ri, p_ir, p_bb, p_cc;
  logic signed [W:0]   as_re1, as_im1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= req_valid;
    end
    if (en) begin
      op1  <= cau_pkg::op_t'(req.req_type);
      p_rr <= PW'(req.a_re) * PW'(req.b_re);
      p_ii <= PW'(req.a_im) * PW'(req.b_im);
      p_ri <= PW'(req.a_re) * PW'(req.b_im);
      p_ir <= PW'(req.a_im) * PW'(req.b_re);
      p_bb <= PW'(req.b_re) * PW'(req.b_re);
      p_cc <= PW'(req.b_im) * PW'(req.b_im);
      if (req.req_type == cau_pkg::OP_SUB) begin
        as_re1 <= (W+1)'(req.a_re) - (W+1)'(req.b_re);
        as_im1 <= (W+1)'(req.a_im) - (W+1)'(req.b_im);
      end else begin
        as_re1 <= (W+1)'(req.a_re) + (W+1)'(req.b_re);
        as_im1 <= (W+1)'(req.a_im) + (W+1)'(req.b_im);
      end
    end
  end

  // stage 2: combine products
  logic                 v2;
  cau_pkg::op_t         op2;
  logic signed [SW-1:0] m_re, m_im, n_re, n_im;
  logic [DW-1:0]        den2;
  logic signed [W:0]    as_re2, as_im2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
    if (en) begin
      op2    <= op1;
      m_re   <= SW'(p_rr) - SW'(p_ii);
      m_im   <= SW'(p_ri) + SW'(p_ir);
      n_re   <= SW'(p_rr) + SW'(p_ii);
      n_im   <= SW'(p_ir) - SW'(p_ri);
      den2   <= DW'(p_bb) + DW'(p_cc);
      as_re2 <= as_re1;
      as_im2 <= as_im1;
    end
  end

  // stage 3: finish add/sub/mul, set up the division
  logic signed [SW-1:0] mt_re, mt_im, ab_re, ab_im;
  logic [W:0]           c_re, c_im;
  cau_pkg::side_t       side3;
  logic [QW-1:0]        dv_re, dv_im;

  always_comb begin
    // multiply: truncate toward zero by biasing negative sums
    mt_re = (m_re + (m_re[SW-1] ? RND : SW'(0))) >>> FRAC_BITS;
    mt_im = (m_im + (m_im[SW-1] ? RND : SW'(0))) >>> FRAC_BITS;
    if (op2 == cau_pkg::OP_MUL) begin
      c_re = clip(mt_re);
      c_im = clip(mt_im);
    end else begin
      c_re = clip(SW'(as_re2));
      c_im = clip(SW'(as_im2));
    end
    ab_re = n_re[SW-1] ? -n_re : n_re;
    ab_im = n_im[SW-1] ? -n_im : n_im;
    dv_re = QW'(ab_re[NW-1:0]) << FRAC_BITS;
    dv_im = QW'(ab_im[NW-1:0]) << FRAC_BITS;
    side3.is_div = (op2 == cau_pkg::OP_DIV);
    side3.dz     = side3.is_div && (den2 == '0);
    side3.res_re = c_re[W-1:0];
    side3.res_im = c_im[W-1:0];
    side3.sat    = c_re[W] | c_im[W];
    side3.neg_re = n_re[SW-1];
    side3.neg_im = n_im[SW-1];
  end

  logic           v3;
  cau_pkg::side_t s3;
  logic [DW-1:0]  den3;
  logic [QW-1:0]  d_re3, d_im3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
    if (en) begin
      s3    <= side3;
      den3  <= den2;
      d_re3 <= dv_re;
      d_im3 <= dv_im;
    end
  end

  // divider chain: one quotient bit per cell, dividend shifts out as quotient shifts in
  logic           cv  [QW+1];
  cau_pkg::side_t cs  [QW+1];
  logic [DW-1:0]  cd  [QW+1];
  logic [QW-1:0]  cqr [QW+1];
  logic [QW-1:0]  cqi [QW+1];
  logic [DW-1:0]  crr [QW+1];
  logic [DW-1:0]  cri [QW+1];

  assign cv[0]  = v3;
  assign cs[0]  = s3;
  assign cd[0]  = den3;
  assign cqr[0] = d_re3;
  assign cqi[0] = d_im3;
  assign crr[0] = '0;
  assign cri[0] = '0;

  for (genvar g = 0; g < QW; g++) begin : g_cell
    cau_div_cell #(
      .QW(QW),
      .DW(DW)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .valid_in (cv[g]),
      .side_in  (cs[g]),
      .den_in   (cd[g]),
      .d_re_in  (cqr[g]),
      .d_im_in  (cqi[g]),
      .r_re_in  (crr[g]),
      .r_im_in  (cri[g]),
      .valid    (cv[g+1]),
      .side     (cs[g+1]),
      .den      (cd[g+1]),
      .d_re     (cqr[g+1]),
      .d_im     (cqi[g+1]),
      .r_re     (crr[g+1]),
      .r_im     (cri[g+1])
    );
  end

  // output: sign and clip the quotient, or pass the early result
  cau_pkg::side_t se;
  logic [QW-1:0]  qr, qi;
  logic           sr, si;
  logic [W-1:0]   vr, vi;
  cau_pkg::res_t  res_next;

  always_comb begin
    se = cs[QW];
    qr = cqr[QW];
    qi = cqi[QW];
    sr = se.neg_re ? (qr > QNEG) : (qr > QPOS);
    si = se.neg_im ? (qi > QNEG) : (qi > QPOS);
    if (sr) begin
      vr = se.neg_re ? MINV[W-1:0] : MAXV[W-1:0];
    end else begin
      vr = se.neg_re ? -qr[W-1:0] : qr[W-1:0];
    end
    if (si) begin
      vi = se.neg_im ? MINV[W-1:0] : MAXV[W-1:0];
    end else begin
      vi = se.neg_im ? -qi[W-1:0] : qi[W-1:0];
    end
    if (!se.is_div) begin
      res_next.res_re      = se.res_re;
      res_next.res_im      = se.res_im;
      res_next.saturated   = se.sat;
      res_next.div_by_zero = 1'b0;
    end else if (se.dz) begin
      res_next.res_re      = '0;
      res_next.res_im      = '0;
      res_next.saturated   = 1'b0;
      res_next.div_by_zero = 1'b1;
    end else begin
      res_next.res_re      = vr;
      res_next.res_im      = vi;
      res_next.saturated   = sr | si;
      res_next.div_by_zero = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (en) begin
      res_valid <= cv[QW];
    end
    if (en) begin
      res <= res_next;
    end
  end

endmodule

### hw/rtl/cau_div_cell.sv
// ----------------------------------------------------------------------------
// cau_div_cell
// one restoring-division step for the real and imaginary quotients
// ----------------------------------------------------------------------------
module cau_div_cell #(
  parameter int QW = 40,
  parameter int DW = 32
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            valid_in,
  input  cau_pkg::side_t  side_in,
  input  logic [DW-1:0]   den_in,
  input  logic [QW-1:0]   d_re_in,
  input  logic [QW-1:0]   d_im_in,
  input  logic [DW-1:0]   r_re_in,
  input  logic [DW-1:0]   r_im_in,
  output logic            valid,
  output cau_pkg::side_t  side,
  output logic [DW-1:0]   den,
  output logic [QW-1:0]   d_re,
  output logic [QW-1:0]   d_im,
  output logic [DW-1:0]   r_re,
  output logic [DW-1:0]   r_im
);

  logic [DW:0] t_re, t_im, s_re, s_im;
  logic        ge_re, ge_im;

  // partial remainder with next dividend bit shifted in
  always_comb begin
    t_re  = {r_re_in, d_re_in[QW-1]};
    t_im  = {r_im_in, d_im_in[QW-1]};
    ge_re = t_re >= {1'b0, den_in};
    ge_im = t_im >= {1'b0, den_in};
    s_re  = t_re - {1'b0, den_in};
    s_im  = t_im - {1'b0, den_in};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= valid_in;
    end
    if (en) begin
      side <= side_in;
      den  <= den_in;
      d_re <= {d_re_in[QW-2:0], ge_re};
      d_im <= {d_im_in[QW-2:0], ge_im};
      r_re <= ge_re ? s_re[DW-1:0] : t_re[DW-1:0];
      r_im <= ge_im ? s_im[DW-1:0] : t_im[DW-1:0];
    end
  end

endmodule

### tb/sv/cau_checker.sv
// ----------------------------------------------------------------------------
// cau_checker
// watches both channels of the complex arithmetic unit, predicts each result
// from its request and compares every field in order of arrival
// ----------------------------------------------------------------------------
module cau_checker (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  input  logic          req_stall,
  input  cau_pkg::req_t req,
  input  logic          res_valid,
  input  logic          res_stall,
  input  cau_pkg::res_t res,
  output int            fail_count,
  output int            pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = 8;
  localparam longint HI = 32767;
  localparam longint LO = -32768;

  cau_pkg::res_t expected_results[$];

  function automatic longint clamp(longint v, inout logic sat);
    if (v > HI) begin
      sat = 1'b1;
      return HI;
    end
    if (v < LO) begin
      sat = 1'b1;
      return LO;
    end
    return v;
  endfunction

  function automatic cau_pkg::res_t complex_result(cau_pkg::req_t r);
    cau_pkg::res_t o;
    longint ar, ai, br, bi, re, im, den;
    logic sat;
    ar = longint'(r.a_re);
    ai = longint'(r.a_im);
    br = longint'(r.b_re);
    bi = longint'(r.b_im);
    re = 0;
    im = 0;
    sat = 1'b0;
    o = '0;
    case (cau_pkg::op_t'(r.req_type))
      cau_pkg::OP_ADD: begin
        re = ar + br;
        im = ai + bi;
      end
      cau_pkg::OP_SUB: begin
        re = ar - br;
        im = ai - bi;
      end
      cau_pkg::OP_MUL: begin
        re = (ar * br - ai * bi) / (64'sd1 <<< FRAC);
        im = (ar * bi + ai * br) / (64'sd1 <<< FRAC);
      end
      default: begin
        den = br * br + bi * bi;
        if (den == 0) o.div_by_zero = 1'b1;
        else begin
          re = ((ar * br + ai * bi) <<< FRAC) / den;
          im = ((ai * br - ar * bi) <<< FRAC) / den;
        end
      end
    endcase
    re = clamp(re, sat);
    im = clamp(im, sat);
    o.res_re = re[15:0];
    o.res_im = im[15:0];
    o.saturated = sat;
    return o;
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    fail_count++;
  endtask

  assign pending = expected_results.size();

  initial fail_count = 0;

  always @(posedge clk) begin
    cau_pkg::res_t e;
    if (!rst) begin
      if (req_valid && !req_stall) expected_results.push_back(complex_result(req));
      if (res_valid && !res_stall) begin
        if (expected_results.size() == 0) report("unexpected result", 1, 0);
        else begin
          e = expected_results.pop_front();
          if (res.res_re !== e.res_re) report("res_re", res.res_re, e.res_re);
          if (res.res_im !== e.res_im) report("res_im", res.res_im, e.res_im);
          if (res.saturated !== e.saturated)
            report("saturated", res.saturated, e.saturated);
          if (res.div_by_zero !== e.div_by_zero)
            report("div_by_zero", res.div_by_zero, e.div_by_zero);
        end
      end
    end
  end
endmodule

### tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// stimulus and verdict for the complex arithmetic unit: directed corner
// requests, then random ones under random gaps, stalls and one long hold-off
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY   = 44;
  localparam int N_RANDOM  = 1830;
  localparam int MAX_CYCLE = 400000;

  logic          clk;
  logic          rst;
  logic          req_valid;
  logic          req_stall;
  cau_pkg::req_t req;
  logic          res_valid;
  logic          res_stall;
  cau_pkg::res_t res;
  int   fail_count;
  int   pending;
  int   cycle;
  int   n_sent;
  bit   quiet;       // no idling on either side
  bit   hold_off;    // receiver holds everything back

  complex_arith_unit uut (
    .clk, .rst, .req_valid, .req_stall, .req, .res_valid, .res_stall, .res
  );

  cau_checker chk (
    .clk, .rst, .req_valid, .req_stall, .req, .res_valid, .res_stall, .res,
    .fail_count, .pending
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // generous cycle limit
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > MAX_CYCLE) begin
      $display("timeout after %0d cycles", cycle);
      $display("[complex_arith_unit] ERROR");
      $finish;
    end
  end

  // receiver: random stall about 19 in 100, none when quiet, all during hold-off
  always @(negedge clk) begin
    if (rst) res_stall <= 1'b0;
    else if (hold_off) res_stall <= 1'b1;
    else if (quiet) res_stall <= 1'b0;
    else res_stall <= ($urandom_range(99) < 19);
  end

  // random corner-biased operand part
  function automatic logic [15:0] pick_part();
    case ($urandom_range(9))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'($signed($urandom_range(1023)) - 512);  // small values
      4: return 16'($signed($urandom_range(8191)) - 4096); // up to 16 in magnitude
      default: return 16'($urandom);
    endcase
  endfunction

  // offer one request, hold it until accepted
  task automatic send(cau_pkg::req_t r);
    req       <= r;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    @(negedge clk);
    n_sent++;
  endtask

  // sender gap, drops valid about 9 in 100 times unless quiet
  task automatic maybe_idle();
    if (!quiet && $urandom_range(99) < 9) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
  endtask

  task automatic send_parts(cau_pkg::op_t op, int ar, int ai, int br, int bi);
    cau_pkg::req_t r;
    r.req_type = op;
    r.a_re = 16'(ar);
    r.a_im = 16'(ai);
    r.b_re = 16'(br);
    r.b_im = 16'(bi);
    send(r);
  endtask

  initial begin
    cau_pkg::req_t r;
    int   k;
    int   waited;
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    res_stall = 1'b0;
    cycle = 0;
    n_sent = 0;
    quiet = 1'b0;
    hold_off = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: every operation, extremes, saturation and zero divisor
    send_parts(cau_pkg::OP_ADD, 32767, -32768, 1, -1);         // clip both ways
    send_parts(cau_pkg::OP_ADD, 256, 512, -256, 100);
    send_parts(cau_pkg::OP_SUB, -32768, 32767, 1, -1);         // clip both ways
    send_parts(cau_pkg::OP_SUB, 0, 0, -32768, -32768);         // negating the minimum
    send_parts(cau_pkg::OP_MUL, 256, 0, 256, 0);               // one times one
    send_parts(cau_pkg::OP_MUL, -32768, -32768, -32768, -32768);
    send_parts(cau_pkg::OP_MUL, 32767, 32767, 32767, -32768);
    send_parts(cau_pkg::OP_MUL, -1, 0, 1, 0);                  // truncation toward zero
    send_parts(cau_pkg::OP_MUL, 0, 256, 0, 256);               // j times j
    send_parts(cau_pkg::OP_DIV, 256, 256, 0, 0);               // zero divisor
    send_parts(cau_pkg::OP_DIV, 0, 0, 0, 0);
    send_parts(cau_pkg::OP_DIV, 256, 0, 256, 0);
    send_parts(cau_pkg::OP_DIV, 32767, -32768, 1, 0);          // huge quotient
    send_parts(cau_pkg::OP_DIV, -32768, -32768, -32768, -32768);
    send_parts(cau_pkg::OP_DIV, 100, -3, 7, 9);
    send_parts(cau_pkg::OP_DIV, -1, 1, 32767, 0);              // tiny quotient
    send_parts(cau_pkg::OP_DIV, 0, 256, 0, 1);
    send_parts(cau_pkg::OP_MUL, 32767, 0, 32767, 0);

    // random phase; a quiet stretch, and one long hold-off of the receiver
    for (k = 0; k < N_RANDOM; k++) begin
      quiet = (k >= 400 && k < 700);
      if (k == 900) begin
        fork
          begin
            hold_off = 1'b1;
            for (waited = 0; waited < 3 * LATENCY; waited++) @(negedge clk);
            hold_off = 1'b0;
          end
        join_none
      end
      r.req_type = 2'($urandom_range(3));
      r.a_re = pick_part();
      r.a_im = pick_part();
      r.b_re = pick_part();
      r.b_im = pick_part();
      if (r.req_type == cau_pkg::OP_DIV && $urandom_range(19) == 0) begin
        r.b_re = '0;
        r.b_im = '0;
      end
      send(r);
      maybe_idle();
    end
    req_valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);

    $display("covered %0d requests over add, subtract, multiply and divide,", n_sent);
    $display("with operand extremes, saturation, zero divisors and receiver hold-off");
    if (fail_count == 0) $display("[complex_arith_unit] OK");
    else $display("[complex_arith_unit] ERROR");
    $finish;
  end
endmodule
